### sv/gbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Shared types, widths and constants of the box suppression unit.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int COORD_W   = 16;
   localparam int AREA_W    = 32;
   localparam int THR_W     = 17;
   localparam int INDEX_W   = 16;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   localparam logic [THR_W-1:0]   THR_RESET = 17'd29491;
   localparam logic [INDEX_W-1:0] INDEX_MAX = 16'hFFFF;

   typedef struct packed {
      logic [COORD_W-1:0] height;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
   } box_type;

   typedef struct packed {
      logic [AREA_W-1:0] area;
      box_type           box;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } ovl_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

### sv/greedy_box_suppression_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy box suppression unit
// Class-agnostic greedy IoU non-maximum suppression over score-sorted boxes.
// ----------------------------------------------------------------------------
// Flow: an input transaction starts a scan with one store read per kept box;
// the read and overlap pipeline then drains, and the result transaction is
// issued once the result slot is free, so a waiting result holds the unit.
// Only one box is in flight at a time.
// Reset: synchronous; store empty, box position zero, threshold 29491.
module greedy_box_suppression_unit #(
   parameter int MAX_KEPT = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // box_left[15:0], box_top[31:16], box_width[47:32], box_height[63:48]
   input  wire logic [gbs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // set_start[0]
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // keep[0], box_index[16:1], store_full[17], zero[23:18]
   output logic [gbs_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [gbs_pkg::THR_W-1:0]           csr_wr_data
);

   localparam int CNT_W  = $clog2(MAX_KEPT + 1);
   localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

   gbs_pkg::state_type state_ff, state_in;

   logic [gbs_pkg::THR_W-1:0]   thr_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            idx_ff;
   logic [gbs_pkg::INDEX_W-1:0] pos_ff;
   logic                        supp_ff;
   logic                        rd_vld_ff;
   gbs_pkg::box_type            cur_box_ff;
   logic [gbs_pkg::AREA_W-1:0]  cur_area_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_keep_ff;
   logic [gbs_pkg::INDEX_W-1:0] rsp_index_ff;
   logic                        rsp_full_ff;

   logic                        accept;
   logic                        slot_free;
   logic                        more;
   logic                        rd_en;
   logic                        finish;
   logic                        keep;
   logic                        room;
   logic                        mem_we;
   gbs_pkg::entry_type          wr_entry;
   gbs_pkg::entry_type          rd_entry;
   gbs_pkg::ovl_status_type     ovl_st;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign more      = (idx_ff < count_ff);
   assign keep      = !supp_ff;
   assign room      = (count_ff < CNT_MAX);
   assign accept    = req_tvalid && req_tready;
   assign mem_we    = finish && keep && room;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbs_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = gbs_pkg::ST_SCAN;
         end
         gbs_pkg::ST_SCAN: begin
            if (!more) state_in = gbs_pkg::ST_DRAIN;
         end
         gbs_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !ovl_st.busy) state_in = gbs_pkg::ST_FINISH;
         end
         gbs_pkg::ST_FINISH: begin
            if (slot_free) state_in = gbs_pkg::ST_IDLE;
         end
         default: state_in = gbs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      finish     = 1'b0;
      unique case (state_ff)
         gbs_pkg::ST_IDLE:   req_tready = 1'b1;
         gbs_pkg::ST_SCAN:   rd_en      = more;
         gbs_pkg::ST_DRAIN:  ;
         gbs_pkg::ST_FINISH: finish     = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbs_pkg::ST_IDLE;
         thr_ff       <= gbs_pkg::THR_RESET;
         count_ff     <= '0;
         pos_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (accept && req_tuser) begin
            count_ff <= '0;
            pos_ff   <= '0;
         end else if (finish) begin
            if (keep && room) begin
               count_ff <= count_ff + 1'b1;
            end
            if (pos_ff != gbs_pkg::INDEX_MAX) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_box_ff  <= req_tdata;
         cur_area_ff <= req_tdata[47:32] * req_tdata[63:48];
         idx_ff      <= '0;
         supp_ff     <= 1'b0;
      end else begin
         if (rd_en) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (ovl_st.hit_valid && ovl_st.hit) begin
            supp_ff <= 1'b1;
         end
      end
      if (finish) begin
         rsp_keep_ff  <= keep;
         rsp_index_ff <= pos_ff;
         rsp_full_ff  <= keep && !room;
      end
   end

   assign wr_entry.area = cur_area_ff;
   assign wr_entry.box  = cur_box_ff;

   gbs_store #(
      .DEPTH  (MAX_KEPT),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   gbs_overlap u_overlap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_vld_ff),
      .cur_box   (cur_box_ff),
      .cur_area  (cur_area_ff),
      .threshold (thr_ff),
      .kept      (rd_entry),
      .status    (ovl_st)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_full_ff, rsp_index_ff, rsp_keep_ff};

   a_full_implies_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[17] && !rsp_tdata[0]))
      else $error("store_full set on a suppressed box");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("kept count beyond store depth");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (!ovl_st.busy && !rd_vld_ff && !rd_en))
      else $error("store write while compares are in flight");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == gbs_pkg::ST_SCAN && idx_ff == '0 && !supp_ff))
      else $error("scan did not start after transaction");

endmodule
`default_nettype wire

### sv/gbs_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kept box store
// Single write, single read memory of kept boxes and areas, registered read.
// ----------------------------------------------------------------------------
module gbs_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire gbs_pkg::entry_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output gbs_pkg::entry_type      rd_data
);

   gbs_pkg::entry_type store_mem [DEPTH];
   gbs_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/gbs_overlap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Overlap test pipeline
// Five stage IoU compare of the current box against one kept box per cycle.
// ----------------------------------------------------------------------------
module gbs_overlap (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire gbs_pkg::box_type                 cur_box,
   input  wire logic [gbs_pkg::AREA_W-1:0]       cur_area,
   input  wire logic [gbs_pkg::THR_W-1:0]        threshold,
   input  wire gbs_pkg::entry_type               kept,
   output gbs_pkg::ovl_status_type               status
);

   localparam int EDGE_W = gbs_pkg::COORD_W + 2;
   localparam int UNI_W  = gbs_pkg::AREA_W + 1;
   localparam int PROD_W = gbs_pkg::THR_W + UNI_W;

   logic signed [EDGE_W-1:0] a_l, a_r, a_t, a_b;
   logic signed [EDGE_W-1:0] b_l, b_r, b_t, b_b;
   logic signed [EDGE_W-1:0] x1, x2, y1, y2, dx, dy;
   logic ox, oy;

   logic                             v1_ff, v2_ff, v3_ff, v4_ff, hv_ff;
   logic [gbs_pkg::COORD_W-1:0]      dx_ff, dy_ff;
   logic [gbs_pkg::AREA_W-1:0]       karea1_ff, karea2_ff;
   logic [gbs_pkg::AREA_W-1:0]       inter2_ff, inter3_ff, inter4_ff;
   logic [UNI_W-1:0]                 uni3_ff, uni_in;
   logic                             nz4_ff;
   logic [PROD_W-1:0]                prod4_ff;
   logic                             hit_ff, hit_in;

   always_comb begin
      a_l = EDGE_W'($signed(cur_box.left));
      a_t = EDGE_W'($signed(cur_box.top));
      a_r = a_l + $signed({2'b00, cur_box.width});
      a_b = a_t + $signed({2'b00, cur_box.height});
      b_l = EDGE_W'($signed(kept.box.left));
      b_t = EDGE_W'($signed(kept.box.top));
      b_r = b_l + $signed({2'b00, kept.box.width});
      b_b = b_t + $signed({2'b00, kept.box.height});
      x1  = (a_l > b_l) ? a_l : b_l;
      y1  = (a_t > b_t) ? a_t : b_t;
      x2  = (a_r < b_r) ? a_r : b_r;
      y2  = (a_b < b_b) ? a_b : b_b;
      dx  = x2 - x1;
      dy  = y2 - y1;
      ox  = (dx > 0);
      oy  = (dy > 0);
   end

   assign uni_in = {1'b0, cur_area} + {1'b0, karea2_ff} - {1'b0, inter2_ff};
   assign hit_in = nz4_ff && (PROD_W'({inter4_ff, 16'h0000}) > prod4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         hv_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         hv_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      // empty or touching overlap gives zero area
      dx_ff     <= (ox && oy) ? dx[gbs_pkg::COORD_W-1:0] : '0;
      dy_ff     <= (ox && oy) ? dy[gbs_pkg::COORD_W-1:0] : '0;
      karea1_ff <= kept.area;
      inter2_ff <= dx_ff * dy_ff;
      karea2_ff <= karea1_ff;
      uni3_ff   <= uni_in;
      inter3_ff <= inter2_ff;
      prod4_ff  <= threshold * uni3_ff;
      inter4_ff <= inter3_ff;
      nz4_ff    <= (uni3_ff != '0);
      hit_ff    <= hit_in;
   end

   assign status.busy      = v1_ff | v2_ff | v3_ff | v4_ff | hv_ff;
   assign status.hit_valid = hv_ff;
   assign status.hit       = hit_ff;

endmodule
`default_nettype wire
